// ===== rtl/fwrl_pkg.sv =====
// shared types and constants for the fixed window rate limiter
package fwrl_pkg;

	localparam int KEY_W = 32;
	localparam int TIME_W = 48;
	localparam int CFG_W = 16;
	localparam int WIN_W = 26;
	localparam int LEFT_W = 27;
	localparam logic [9:0] MS_PER_S = 10'd1000;
	localparam logic [26:0] MS_ROUND = 27'd999;
	localparam logic [24:0] DIV_MUL = 25'd17179870;
	localparam int DIV_SHIFT = 31;

	localparam logic REG_MAX_REQUESTS = 1'b0;
	localparam logic REG_WINDOW_SECONDS = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] client_key;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic allowed;
		logic [15:0] limit_value;
		logic [15:0] remaining_allowance;
		logic [15:0] retry_after_s;
		logic status;
	} res_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic look;
		logic sweep;
		logic [TIME_W-1:0] limit;
		logic wr;
		logic wr_hit;
		logic [TIME_W-1:0] start;
		logic [15:0] count;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic [TIME_W-1:0] start;
		logic [15:0] count;
	} chain_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LOOK,
		ST_ELAP,
		ST_DEC,
		ST_DIV1,
		ST_DIV2,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/fwrl_cell.sv =====
// one client table slot with its link in the lookup chain
module fwrl_cell (
	input  logic clk,
	input  logic arst_n,
	input  fwrl_pkg::cmd_t cmd,
	input  fwrl_pkg::chain_t chain_in,
	output fwrl_pkg::chain_t chain_out
);

	logic valid_q;
	logic [fwrl_pkg::KEY_W-1:0] key_q;
	logic [fwrl_pkg::TIME_W-1:0] start_q;
	logic [15:0] count_q;
	logic sel_hit_q;
	logic sel_free_q;
	logic mine_hit;
	logic take_hit;
	logic take_free;
	logic wr_me;

	assign mine_hit = valid_q && (key_q == cmd.key);
	assign take_hit = mine_hit && !chain_in.hit;
	assign take_free = !valid_q && !chain_in.free;
	assign wr_me = cmd.wr && (cmd.wr_hit ? sel_hit_q : sel_free_q);

	always_comb begin
		chain_out.hit = chain_in.hit | mine_hit;
		chain_out.free = chain_in.free | !valid_q;
		chain_out.start = take_hit ? start_q : chain_in.start;
		chain_out.count = take_hit ? count_q : chain_in.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_hit_q <= 1'b0;
			sel_free_q <= 1'b0;
		end else begin
			if (cmd.look) begin
				sel_hit_q <= take_hit;
				sel_free_q <= take_free;
			end
			if (wr_me) begin
				valid_q <= 1'b1;
			end else if (cmd.sweep && valid_q && (start_q < cmd.limit)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me) begin
			key_q <= cmd.key;
			start_q <= cmd.start;
			count_q <= cmd.count;
		end
	end

endmodule

// ===== rtl/fixed_window_rate_limiter.sv =====
// top level: per-client fixed window rate limiter over a chain of table cells
// a disabled limit (max 0) goes straight to the result; otherwise the sequencer
// runs an optional sweep, lookup, elapsed time and decision, then ST_DIV1 and
// ST_DIV2 when denied on count; one item at a time: input stalls while busy
// the sweep runs as an extra state once every SWEEP_PERIOD limited checks
// reset clears all slot valid bits, the sweep counter and restores config defaults
module fixed_window_rate_limiter #(
	parameter int TABLE_ENTRIES = 16,
	parameter int SWEEP_PERIOD = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  fwrl_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output fwrl_pkg::res_t out_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [fwrl_pkg::CFG_W-1:0] cfg_data
);

	localparam int CW = $clog2(SWEEP_PERIOD + 1);

	fwrl_pkg::state_t state_q, state_d;
	fwrl_pkg::cmd_t cmd;
	fwrl_pkg::chain_t chain [TABLE_ENTRIES+1];
	fwrl_pkg::res_t res_q;
	fwrl_pkg::res_t out_q;

	logic [15:0] max_q;
	logic [15:0] ws_q;
	logic [CW-1:0] sweep_cnt_q;
	logic [fwrl_pkg::KEY_W-1:0] key_q;
	logic [fwrl_pkg::TIME_W-1:0] now_q;
	logic [fwrl_pkg::WIN_W-1:0] win_q;
	logic hit_q;
	logic free_q;
	logic [fwrl_pkg::TIME_W-1:0] start_q;
	logic [15:0] count_q;
	logic [fwrl_pkg::WIN_W-1:0] elapsed_q;
	logic [fwrl_pkg::LEFT_W-1:0] left_q;
	logic [48:0] prod_q;
	logic out_valid_q;

	logic accept;
	logic load_out;
	logic [fwrl_pkg::LEFT_W-1:0] span;
	logic sweep_go;
	logic [fwrl_pkg::TIME_W-1:0] elapsed_raw;
	logic restart;
	logic fresh;
	logic deny_count;
	logic [15:0] count_inc;
	logic [16:0] secs;

	assign in_stall = (state_q != fwrl_pkg::ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign load_out = (state_q == fwrl_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign span = {1'b0, win_q} << 1;
	assign sweep_go = now_q >= {{(fwrl_pkg::TIME_W-fwrl_pkg::LEFT_W){1'b0}}, span};
	assign elapsed_raw = (now_q >= start_q) ? (now_q - start_q) : '0;
	assign restart = hit_q && (elapsed_raw >= {{(fwrl_pkg::TIME_W-fwrl_pkg::WIN_W){1'b0}}, win_q});
	assign fresh = !hit_q || restart;
	assign deny_count = count_q >= max_q;
	assign count_inc = count_q + 16'd1;
	assign secs = prod_q[fwrl_pkg::DIV_SHIFT +: 17];

	assign chain[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		fwrl_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.chain_in(chain[i]),
			.chain_out(chain[i+1])
		);
	end

	always_comb begin
		cmd = '0;
		cmd.key = key_q;
		cmd.look = (state_q == fwrl_pkg::ST_LOOK);
		cmd.sweep = (state_q == fwrl_pkg::ST_SWEEP) && sweep_go;
		cmd.limit = now_q - {{(fwrl_pkg::TIME_W-fwrl_pkg::LEFT_W){1'b0}}, span};
		cmd.wr = (state_q == fwrl_pkg::ST_DEC) && (hit_q || free_q) && !deny_count;
		cmd.wr_hit = hit_q;
		cmd.start = start_q;
		cmd.count = count_inc;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fwrl_pkg::ST_IDLE: begin
				if (accept) begin
					if (max_q == '0) begin
						state_d = fwrl_pkg::ST_DONE;
					end else if (sweep_cnt_q == CW'(SWEEP_PERIOD - 1)) begin
						state_d = fwrl_pkg::ST_SWEEP;
					end else begin
						state_d = fwrl_pkg::ST_LOOK;
					end
				end
			end
			fwrl_pkg::ST_SWEEP: state_d = fwrl_pkg::ST_LOOK;
			fwrl_pkg::ST_LOOK: state_d = fwrl_pkg::ST_ELAP;
			fwrl_pkg::ST_ELAP: state_d = fwrl_pkg::ST_DEC;
			fwrl_pkg::ST_DEC: begin
				if ((hit_q || free_q) && deny_count) begin
					state_d = fwrl_pkg::ST_DIV1;
				end else begin
					state_d = fwrl_pkg::ST_DONE;
				end
			end
			fwrl_pkg::ST_DIV1: state_d = fwrl_pkg::ST_DIV2;
			fwrl_pkg::ST_DIV2: state_d = fwrl_pkg::ST_DONE;
			fwrl_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = fwrl_pkg::ST_IDLE;
				end
			end
			default: state_d = fwrl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwrl_pkg::ST_IDLE;
			max_q <= 16'd100;
			ws_q <= 16'd60;
			sweep_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					fwrl_pkg::REG_MAX_REQUESTS: max_q <= cfg_data;
					fwrl_pkg::REG_WINDOW_SECONDS: ws_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && (max_q != '0)) begin
				if (sweep_cnt_q == CW'(SWEEP_PERIOD - 1)) begin
					sweep_cnt_q <= '0;
				end else begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fwrl_pkg::ST_IDLE: begin
				key_q <= in_data.client_key;
				now_q <= in_data.now_ms;
				win_q <= fwrl_pkg::WIN_W'(ws_q) * fwrl_pkg::WIN_W'(fwrl_pkg::MS_PER_S);
				res_q <= fwrl_pkg::res_t'{allowed: 1'b1, default: '0};
			end
			fwrl_pkg::ST_LOOK: begin
				hit_q <= chain[TABLE_ENTRIES].hit;
				free_q <= chain[TABLE_ENTRIES].free;
				start_q <= chain[TABLE_ENTRIES].start;
				count_q <= chain[TABLE_ENTRIES].count;
				res_q.limit_value <= max_q;
			end
			fwrl_pkg::ST_ELAP: begin
				if (fresh) begin
					start_q <= now_q;
					count_q <= '0;
					elapsed_q <= '0;
				end else begin
					elapsed_q <= elapsed_raw[fwrl_pkg::WIN_W-1:0];
				end
			end
			fwrl_pkg::ST_DEC: begin
				left_q <= fwrl_pkg::LEFT_W'(win_q - elapsed_q) + fwrl_pkg::MS_ROUND;
				if (!hit_q && !free_q) begin
					res_q.allowed <= 1'b0;
					res_q.retry_after_s <= 16'd1;
					res_q.status <= 1'b1;
				end else if (deny_count) begin
					res_q.allowed <= 1'b0;
				end else begin
					res_q.remaining_allowance <= max_q - count_inc;
				end
			end
			fwrl_pkg::ST_DIV1: begin
				prod_q <= left_q[fwrl_pkg::LEFT_W-1:3] * fwrl_pkg::DIV_MUL;
			end
			fwrl_pkg::ST_DIV2: begin
				res_q.retry_after_s <= (secs == '0) ? 16'd1 : secs[15:0];
			end
			default: ;
		endcase
		if (load_out) begin
			out_q <= res_q;
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != fwrl_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_full_denies: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status) |-> (!out_data.allowed && out_data.retry_after_s == 16'd1))
		else $error("table full result not a denial");
	a_deny_retry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.allowed) |-> (out_data.retry_after_s != '0))
		else $error("denial without retry time");
	a_allow_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.allowed) |-> (out_data.retry_after_s == '0 && !out_data.status))
		else $error("admitted item carries denial fields");

endmodule
